// ===== rtl/dnsrap_pkg.sv =====
// Shared types and constants for the DNS response address parser.
// Holds the parse phase encoding, the queue entry layout and status codes.
// No dependencies.
package dnsrap_pkg;

    typedef enum logic [12:0] {
        PH_HEADER = 13'b0000000000001,
        PH_QNAME  = 13'b0000000000010,
        PH_QPTR   = 13'b0000000000100,
        PH_QLABEL = 13'b0000000001000,
        PH_QFIXED = 13'b0000000010000,
        PH_ANAME  = 13'b0000000100000,
        PH_APTR   = 13'b0000001000000,
        PH_ALABEL = 13'b0000010000000,
        PH_AFIXED = 13'b0000100000000,
        PH_ARDATA = 13'b0001000000000,
        PH_ABAD   = 13'b0010000000000,
        PH_DONE   = 13'b0100000000000,
        PH_DRAIN  = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        logic        has_addr;
        logic        is_v6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] query_id;
        logic        has_stat;
        logic [2:0]  status;
    } t_entry;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PKT_ERR  = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_FORMAT   = 3'd3;
    localparam logic [2:0] ST_SERVFAIL = 3'd4;
    localparam logic [2:0] ST_NXDOMAIN = 3'd5;
    localparam logic [2:0] ST_REFUSED  = 3'd6;
    localparam logic [2:0] ST_OTHER    = 3'd7;

    localparam logic [3:0] RCODE_NOERROR  = 4'd0;
    localparam logic [3:0] RCODE_FORMERR  = 4'd1;
    localparam logic [3:0] RCODE_SERVFAIL = 4'd2;
    localparam logic [3:0] RCODE_NXDOMAIN = 4'd3;
    localparam logic [3:0] RCODE_REFUSED  = 4'd5;

    localparam logic [3:0] HDR_ID_HI    = 4'd0;
    localparam logic [3:0] HDR_ID_LO    = 4'd1;
    localparam logic [3:0] HDR_FLAGS_HI = 4'd2;
    localparam logic [3:0] HDR_FLAGS_LO = 4'd3;
    localparam logic [3:0] HDR_QD_HI    = 4'd4;
    localparam logic [3:0] HDR_QD_LO    = 4'd5;
    localparam logic [3:0] HDR_AN_HI    = 4'd6;
    localparam logic [3:0] HDR_AN_LO    = 4'd7;
    localparam logic [3:0] HDR_LAST     = 4'd11;

    localparam logic [3:0] QFIX_LAST    = 4'd3;
    localparam logic [3:0] AFIX_TYPE_HI = 4'd0;
    localparam logic [3:0] AFIX_TYPE_LO = 4'd1;
    localparam logic [3:0] AFIX_RDLEN_HI = 4'd8;
    localparam logic [3:0] AFIX_RDLEN_LO = 4'd9;

    localparam logic [7:0]  PTR_MASK  = 8'hC0;
    localparam logic [7:0]  FLAG_QR   = 8'h80;
    localparam logic [7:0]  FLAG_TC   = 8'h02;
    localparam logic [15:0] TYPE_A    = 16'h0001;
    localparam logic [15:0] TYPE_AAAA = 16'h001C;
    localparam logic [15:0] V4_LEN    = 16'd4;
    localparam logic [15:0] V6_LEN    = 16'd16;

endpackage

// ===== rtl/dns_response_address_parser.sv =====
// DNS response address parser, top level.
// Usage:
//   Input channel: drive i_data_byte and i_last_byte with push; a byte is
//   taken at a clock edge where push is high and full is low. i_last_byte
//   marks the final byte of a packet.
//   Result channel: while empty is low the oldest result is on the o_ ports;
//   it is taken at a clock edge where pop is high.
//   Each A or AAAA answer yields an address result on the byte that ends its
//   rdata; the final byte of a packet yields a status result (o_last high)
//   carrying the query id. Both can come from one byte, address first.
//   Path: a result is written into the queue at the edge that takes the
//   byte causing it, then moves to the output register once no earlier result waits.
//   Throughput: one byte per cycle while full is low; the parser walks one byte per cycle and
//   a result takes one pop, so a byte that closes both an answer and the
//   packet needs two pops.
//   Stall: results wait in a QUEUE_DEPTH-entry queue and an output register;
//   full rises once the queue is full and the parser holds.
//   Reset: synchronous, active low; clears the parser and drops every queued
//   and held result.
// Depends on dnsrap_pkg, dnsrap_front, dnsrap_queue, dnsrap_back.
module dns_response_address_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic        o_is_v6,
    output logic [63:0] o_addr_high,
    output logic [63:0] o_addr_low,
    output logic [15:0] o_query_id,
    output logic [2:0]  o_status,
    output logic        o_last
);
    import dnsrap_pkg::*;

    logic   q_wr;
    logic   q_full;
    logic   q_rd;
    logic   q_empty;
    t_entry q_wr_ent;
    t_entry q_rd_ent;

    dnsrap_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_q_full    (q_full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_full      (full),
        .o_q_wr      (q_wr),
        .o_q_ent     (q_wr_ent)
    );

    dnsrap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_wr_ent (q_wr_ent),
        .i_rd     (q_rd),
        .o_rd_ent (q_rd_ent),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    dnsrap_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_ent       (q_rd_ent),
        .i_q_empty     (q_empty),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_result_kind (o_result_kind),
        .o_is_v6       (o_is_v6),
        .o_addr_high   (o_addr_high),
        .o_addr_low    (o_addr_low),
        .o_query_id    (o_query_id),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

// ===== rtl/dnsrap_front.sv =====
// Front end: parses one packet byte per cycle while the queue is not full and forms queue entries.
// Depends on dnsrap_pkg.
module dnsrap_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_q_full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_full,
    output logic             o_q_wr,
    output dnsrap_pkg::t_entry o_q_ent
);
    import dnsrap_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_fbc, n_fbc;
    logic [15:0] r_qleft, n_qleft;
    logic [15:0] r_aleft, n_aleft;
    logic [5:0]  r_lbl, n_lbl;
    logic [15:0] r_rtype, n_rtype;
    logic [15:0] r_rdleft, n_rdleft;
    logic [63:0] r_acc_hi, n_acc_hi;
    logic [63:0] r_acc_lo, n_acc_lo;
    logic [15:0] r_qid, n_qid;
    logic [2:0]  r_err, n_err;

    logic        accept;
    logic [3:0]  fbc_inc;
    logic        bad_len;
    t_entry      ent;

    assign accept  = i_push && !i_q_full;
    assign o_full  = i_q_full;
    assign fbc_inc = r_fbc + 4'd1;

    always_comb begin
        n_phase  = r_phase;
        n_fbc    = r_fbc;
        n_qleft  = r_qleft;
        n_aleft  = r_aleft;
        n_lbl    = r_lbl;
        n_rtype  = r_rtype;
        n_rdleft = r_rdleft;
        n_acc_hi = r_acc_hi;
        n_acc_lo = r_acc_lo;
        n_qid    = r_qid;
        n_err    = r_err;
        bad_len  = 1'b0;
        ent      = '0;

        case (r_phase)
            PH_HEADER: begin
                case (r_fbc)
                    HDR_ID_HI: n_qid = {i_data_byte, 8'h00};
                    HDR_ID_LO: n_qid = {r_qid[15:8], i_data_byte};
                    HDR_FLAGS_HI: begin
                        if ((i_data_byte & FLAG_QR) == 8'h00) begin
                            n_err = ST_PKT_ERR;
                        end else if ((i_data_byte & FLAG_TC) != 8'h00) begin
                            n_err = ST_TRUNC;
                        end
                    end
                    HDR_FLAGS_LO: begin
                        if (r_err == ST_OK) begin
                            case (i_data_byte[3:0])
                                RCODE_NOERROR:  n_err = ST_OK;
                                RCODE_FORMERR:  n_err = ST_FORMAT;
                                RCODE_SERVFAIL: n_err = ST_SERVFAIL;
                                RCODE_NXDOMAIN: n_err = ST_NXDOMAIN;
                                RCODE_REFUSED:  n_err = ST_REFUSED;
                                default:        n_err = ST_OTHER;
                            endcase
                        end
                    end
                    HDR_QD_HI: n_qleft = {i_data_byte, 8'h00};
                    HDR_QD_LO: n_qleft = {r_qleft[15:8], i_data_byte};
                    HDR_AN_HI: n_aleft = {i_data_byte, 8'h00};
                    HDR_AN_LO: n_aleft = {r_aleft[15:8], i_data_byte};
                    default: ;
                endcase
                n_fbc = fbc_inc;
                if (r_fbc == HDR_LAST) begin
                    n_fbc = 4'd0;
                    if (n_err != ST_OK) begin
                        n_phase = PH_DRAIN;
                    end else if (n_qleft != 16'd0) begin
                        n_phase = PH_QNAME;
                    end else if (n_aleft != 16'd0) begin
                        n_phase = PH_ANAME;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_QNAME, PH_ANAME: begin
                if ((i_data_byte & PTR_MASK) != 8'h00) begin
                    n_phase = (r_phase == PH_QNAME) ? PH_QPTR : PH_APTR;
                end else if (i_data_byte == 8'h00) begin
                    n_fbc   = 4'd0;
                    n_phase = (r_phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                end else begin
                    n_lbl   = i_data_byte[5:0];
                    n_phase = (r_phase == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
                end
            end
            PH_QPTR: begin
                n_fbc   = 4'd0;
                n_phase = PH_QFIXED;
            end
            PH_APTR: begin
                n_fbc   = 4'd0;
                n_phase = PH_AFIXED;
            end
            PH_QLABEL, PH_ALABEL: begin
                n_lbl = r_lbl - 6'd1;
                if (n_lbl == 6'd0) begin
                    n_phase = (r_phase == PH_QLABEL) ? PH_QNAME : PH_ANAME;
                end
            end
            PH_QFIXED: begin
                n_fbc = fbc_inc;
                if (r_fbc == QFIX_LAST) begin
                    n_fbc   = 4'd0;
                    n_qleft = r_qleft - 16'd1;
                    if (n_qleft != 16'd0) begin
                        n_phase = PH_QNAME;
                    end else if (r_aleft != 16'd0) begin
                        n_phase = PH_ANAME;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_AFIXED: begin
                case (r_fbc)
                    AFIX_TYPE_HI:  n_rtype  = {i_data_byte, 8'h00};
                    AFIX_TYPE_LO:  n_rtype  = {r_rtype[15:8], i_data_byte};
                    AFIX_RDLEN_HI: n_rdleft = {i_data_byte, 8'h00};
                    AFIX_RDLEN_LO: n_rdleft = {r_rdleft[15:8], i_data_byte};
                    default: ;
                endcase
                n_fbc = fbc_inc;
                if (r_fbc == AFIX_RDLEN_LO) begin
                    n_fbc    = 4'd0;
                    n_acc_hi = 64'd0;
                    n_acc_lo = 64'd0;
                    bad_len  = (n_rtype == TYPE_A && n_rdleft != V4_LEN) ||
                               (n_rtype == TYPE_AAAA && n_rdleft != V6_LEN);
                    if (bad_len) begin
                        if (n_rdleft == 16'd0) begin
                            n_err   = ST_FORMAT;
                            n_phase = PH_DRAIN;
                        end else begin
                            n_phase = PH_ABAD;
                        end
                    end else if (n_rdleft == 16'd0) begin
                        n_aleft = r_aleft - 16'd1;
                        n_phase = (n_aleft != 16'd0) ? PH_ANAME : PH_DONE;
                    end else begin
                        n_phase = PH_ARDATA;
                    end
                end
            end
            PH_ARDATA: begin
                n_acc_hi = {r_acc_hi[55:0], r_acc_lo[63:56]};
                n_acc_lo = {r_acc_lo[55:0], i_data_byte};
                n_rdleft = r_rdleft - 16'd1;
                if (n_rdleft == 16'd0) begin
                    if (r_rtype == TYPE_A) begin
                        ent.has_addr = 1'b1;
                        ent.addr_low = {32'd0, n_acc_lo[31:0]};
                    end else if (r_rtype == TYPE_AAAA) begin
                        ent.has_addr  = 1'b1;
                        ent.is_v6     = 1'b1;
                        ent.addr_high = n_acc_hi;
                        ent.addr_low  = n_acc_lo;
                    end
                    n_aleft = r_aleft - 16'd1;
                    n_phase = (n_aleft != 16'd0) ? PH_ANAME : PH_DONE;
                end
            end
            PH_ABAD: begin
                n_rdleft = r_rdleft - 16'd1;
                if (n_rdleft == 16'd0) begin
                    n_err   = ST_FORMAT;
                    n_phase = PH_DRAIN;
                end
            end
            default: ;
        endcase

        ent.query_id = n_qid;

        if (i_last_byte) begin
            ent.has_stat = 1'b1;
            if (n_phase == PH_DRAIN) begin
                ent.status = n_err;
            end else if (n_phase == PH_DONE) begin
                ent.status = ST_OK;
            end else if (n_phase == PH_QFIXED) begin
                ent.status = ST_TRUNC;
            end else begin
                ent.status = ST_PKT_ERR;
            end
            n_phase  = PH_HEADER;
            n_fbc    = 4'd0;
            n_qleft  = 16'd0;
            n_aleft  = 16'd0;
            n_lbl    = 6'd0;
            n_rtype  = 16'd0;
            n_rdleft = 16'd0;
            n_acc_hi = 64'd0;
            n_acc_lo = 64'd0;
            n_qid    = 16'd0;
            n_err    = ST_OK;
        end
    end

    assign o_q_wr  = accept && (ent.has_addr || ent.has_stat);
    assign o_q_ent = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_fbc    <= 4'd0;
            r_qleft  <= 16'd0;
            r_aleft  <= 16'd0;
            r_lbl    <= 6'd0;
            r_rtype  <= 16'd0;
            r_rdleft <= 16'd0;
            r_acc_hi <= 64'd0;
            r_acc_lo <= 64'd0;
            r_qid    <= 16'd0;
            r_err    <= ST_OK;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_fbc    <= n_fbc;
            r_qleft  <= n_qleft;
            r_aleft  <= n_aleft;
            r_lbl    <= n_lbl;
            r_rtype  <= n_rtype;
            r_rdleft <= n_rdleft;
            r_acc_hi <= n_acc_hi;
            r_acc_lo <= n_acc_lo;
            r_qid    <= n_qid;
            r_err    <= n_err;
        end
    end

    a_addr_only_from_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_wr && o_q_ent.has_addr) |-> (r_phase == PH_ARDATA))
        else $error("address entry formed outside rdata phase");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (r_phase == PH_HEADER && r_fbc == 4'd0 &&
                                     r_qid == 16'd0 && r_err == ST_OK))
        else $error("parser did not restart after final byte");

endmodule

// ===== rtl/dnsrap_queue.sv =====
// Short entry queue between the parser front end and the result stage.
// Depends on dnsrap_pkg.
module dnsrap_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  dnsrap_pkg::t_entry i_wr_ent,
    input  logic               i_rd,
    output dnsrap_pkg::t_entry o_rd_ent,
    output logic               o_full,
    output logic               o_empty
);
    import dnsrap_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               wr_en, rd_en;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign wr_en    = i_wr && !o_full;
    assign rd_en    = i_rd && !o_empty;
    assign o_rd_ent = r_mem[r_rptr];
    assign n_wptr   = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
    assign n_rptr   = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wr_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= n_wptr;
            end
            if (rd_en) begin
                r_rptr <= n_rptr;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count missed a write");

endmodule

// ===== rtl/dnsrap_back.sv =====
// Result stage: holds one queue entry and presents its address result, if it has one,
// then its status result, if it has one. Depends on dnsrap_pkg.
module dnsrap_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dnsrap_pkg::t_entry i_q_ent,
    input  logic               i_q_empty,
    output logic               o_q_rd,
    input  logic               i_pop,
    output logic               o_empty,
    output logic               o_result_kind,
    output logic               o_is_v6,
    output logic [63:0]        o_addr_high,
    output logic [63:0]        o_addr_low,
    output logic [15:0]        o_query_id,
    output logic [2:0]         o_status,
    output logic               o_last
);
    import dnsrap_pkg::*;

    t_entry r_ent;
    logic   r_valid;
    logic   r_pend;
    logic   take;
    logic   ent_done;

    assign take     = i_pop && r_valid;
    assign ent_done = !(r_pend && r_ent.has_stat);
    assign o_q_rd   = !i_q_empty && (!r_valid || (take && ent_done));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
            r_pend  <= i_q_ent.has_addr;
        end else if (take) begin
            if (ent_done) begin
                r_valid <= 1'b0;
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_ent <= i_q_ent;
        end
    end

    assign o_empty       = !r_valid;
    assign o_result_kind = !r_pend;
    assign o_is_v6       = r_pend ? r_ent.is_v6 : 1'b0;
    assign o_addr_high   = r_pend ? r_ent.addr_high : 64'd0;
    assign o_addr_low    = r_pend ? r_ent.addr_low : 64'd0;
    assign o_query_id    = r_ent.query_id;
    assign o_status      = r_pend ? ST_OK : r_ent.status;
    assign o_last        = !r_pend;

    a_entry_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_pend || r_ent.has_stat))
        else $error("held entry carries no result");

    a_status_follows_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_pend && r_ent.has_stat) |=> (r_valid && !r_pend))
        else $error("status result lost after address result");

endmodule
